FILE: rtl/rpop_pkg.sv
// Package for the route pickup overload penalty block.
// Holds the stop and result item types, request and register codes, and the lane control struct.
// Has no dependencies. Every other file in rtl/ imports it.
`default_nettype none

package rpop_pkg;

	localparam int DEMAND_BITS      = 16;
	localparam int ACC_BITS_DEFAULT = 32;
	localparam int PENALTY_BITS     = 32;
	localparam int CFG_INDEX_BITS   = 1;

	localparam logic [1:0] REQ_DELIVERY = 2'd0;
	localparam logic [1:0] REQ_PICKUP   = 2'd1;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_CAPACITY_ONE = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CAPACITY_TWO = 1'd1;

	typedef struct packed {
		logic                   is_depot;
		logic [1:0]             req_type;
		logic [DEMAND_BITS-1:0] demand_one;
		logic [DEMAND_BITS-1:0] demand_two;
		logic                   last_stop;
	} stop_t;

	typedef struct packed {
		logic [PENALTY_BITS-1:0] penalty_one;
		logic [PENALTY_BITS-1:0] penalty_two;
	} penalty_t;

	typedef struct packed {
		logic load;
		logic close;
		logic add_over;
		logic clear_total;
		logic first_pick;
		logic is_delivery;
		logic is_pickup;
	} rpop_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/rpop_lane.sv
// One load dimension: trip delivery sum, net load change, best pickup change and the total.
// Closes a trip by adding its positive overload to the saturating total.
// Depends on rpop_pkg.
`default_nettype none

module rpop_lane
	import rpop_pkg::*;
#(
	parameter int ACC_BITS = ACC_BITS_DEFAULT
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire rpop_ctrl_t              ctrl,
	input  wire logic [DEMAND_BITS-1:0]  demand,
	input  wire logic [DEMAND_BITS-1:0]  capacity,
	output logic      [PENALTY_BITS-1:0] penalty
);

	localparam int WIDE = ((ACC_BITS > DEMAND_BITS) ? ACC_BITS : DEMAND_BITS) + 3;
	localparam logic signed [WIDE-1:0] SAT_POS = {{(WIDE-ACC_BITS){1'b0}}, {ACC_BITS{1'b1}}};
	localparam logic signed [WIDE-1:0] SAT_NEG = -SAT_POS;

	logic        [ACC_BITS-1:0] deliv_q;
	logic signed [ACC_BITS:0]   net_q;
	logic signed [ACC_BITS:0]   best_q;
	logic        [ACC_BITS-1:0] total_q;

	logic signed [WIDE-1:0] dem_w;
	logic signed [WIDE-1:0] cap_w;
	logic signed [WIDE-1:0] deliv_w;
	logic signed [WIDE-1:0] net_w;
	logic signed [WIDE-1:0] best_w;
	logic signed [WIDE-1:0] total_w;
	logic signed [WIDE-1:0] deliv_sum;
	logic signed [WIDE-1:0] net_sum;
	logic signed [WIDE-1:0] net_clamped;
	logic signed [WIDE-1:0] over;
	logic signed [WIDE-1:0] total_sum;

	logic        [ACC_BITS-1:0] deliv_new;
	logic signed [ACC_BITS:0]   net_new;
	logic signed [ACC_BITS:0]   best_new;
	logic        [ACC_BITS-1:0] total_closed;
	logic [ACC_BITS+PENALTY_BITS-1:0] penalty_ext;

	always_comb begin
		dem_w   = signed'({{(WIDE-DEMAND_BITS){1'b0}}, demand});
		cap_w   = signed'({{(WIDE-DEMAND_BITS){1'b0}}, capacity});
		deliv_w = signed'({{(WIDE-ACC_BITS){1'b0}}, deliv_q});
		net_w   = signed'({{(WIDE-ACC_BITS-1){net_q[ACC_BITS]}}, net_q});
		best_w  = signed'({{(WIDE-ACC_BITS-1){best_q[ACC_BITS]}}, best_q});
		total_w = signed'({{(WIDE-ACC_BITS){1'b0}}, total_q});

		deliv_sum = deliv_w + dem_w;
		deliv_new = (deliv_sum > SAT_POS) ? {ACC_BITS{1'b1}} : deliv_sum[ACC_BITS-1:0];

		net_sum = ctrl.is_delivery ? (net_w - dem_w) : (net_w + dem_w);
		if (net_sum > SAT_POS) begin
			net_clamped = SAT_POS;
		end else if (net_sum < SAT_NEG) begin
			net_clamped = SAT_NEG;
		end else begin
			net_clamped = net_sum;
		end
		net_new  = net_clamped[ACC_BITS:0];
		best_new = (ctrl.first_pick || (net_new > best_q)) ? net_new : best_q;

		over      = deliv_w + best_w - cap_w;
		total_sum = total_w + over;
		if (ctrl.add_over && (over > 0)) begin
			total_closed = (total_sum > SAT_POS) ? {ACC_BITS{1'b1}}
				: total_sum[ACC_BITS-1:0];
		end else begin
			total_closed = total_q;
		end

		penalty_ext = {{PENALTY_BITS{1'b0}}, total_closed};
		penalty     = penalty_ext[PENALTY_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deliv_q <= '0;
			net_q   <= '0;
			best_q  <= '0;
			total_q <= '0;
		end else if (ctrl.close) begin
			deliv_q <= '0;
			net_q   <= '0;
			best_q  <= '0;
			total_q <= ctrl.clear_total ? '0 : total_closed;
		end else if (ctrl.load) begin
			if (ctrl.is_delivery) begin
				deliv_q <= deliv_new;
			end
			net_q <= net_new;
			if (ctrl.is_pickup) begin
				best_q <= best_new;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/route_pickup_overload_penalty_unit.sv
// Top level of the route pickup overload penalty block.
// Instantiates two rpop_lane units and depends on rpop_pkg.
//
// Usage:
// Stops of a route enter on in_valid/in_ready/in_item, one item per stop. A depot stop
// opens a trip, and the next depot or the route's last stop closes it. The last stop
// produces one result item on out_valid/out_ready/out_item that carries both penalty
// totals. Every other stop produces no result.
// Capacities are written on cfg_we/cfg_index/cfg_data. Index 0 is capacity one and
// index 1 is capacity two. Write them only while no route is in flight.
// Timing: an accepted stop goes into an input register and is folded into the running
// sums in the next cycle. The result of a last stop goes from the input register into the
// output register, which drives out_valid. One stop can be accepted in every cycle but for the stall below.
// If the receiver stalls, the result is held in the output register. Stops that are not
// last stops keep flowing. A second last stop waits in the input register, and in_ready
// stays low until the held result is taken.
// Reset clears the trip state, the totals, the capacities and both valid flags.
`default_nettype none

module route_pickup_overload_penalty_unit
	import rpop_pkg::*;
#(
	parameter int ACC_BITS = ACC_BITS_DEFAULT
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire stop_t                     in_item,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output penalty_t                       out_item,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [DEMAND_BITS-1:0]    cfg_data
);

	logic                   s1_valid;
	stop_t                  stop_s1;
	logic                   out_valid_q;
	penalty_t               result_q;
	logic                   trip_open_q;
	logic                   pickup_seen_q;
	logic [DEMAND_BITS-1:0] capacity_one_q;
	logic [DEMAND_BITS-1:0] capacity_two_q;

	logic                    advance;
	rpop_ctrl_t              ctrl;
	logic [PENALTY_BITS-1:0] pen_one;
	logic [PENALTY_BITS-1:0] pen_two;

	always_comb begin
		advance  = s1_valid && (!stop_s1.last_stop || !out_valid_q || out_ready);
		in_ready = !s1_valid || advance;

		ctrl.close       = advance && (stop_s1.last_stop || stop_s1.is_depot);
		ctrl.load        = advance && !stop_s1.last_stop && !stop_s1.is_depot && trip_open_q;
		ctrl.add_over    = ctrl.close && trip_open_q && pickup_seen_q;
		ctrl.clear_total = advance && stop_s1.last_stop;
		ctrl.first_pick  = !pickup_seen_q;
		ctrl.is_delivery = (stop_s1.req_type == REQ_DELIVERY);
		ctrl.is_pickup   = (stop_s1.req_type == REQ_PICKUP);
	end

	rpop_lane #(.ACC_BITS(ACC_BITS)) u_lane_one (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.demand   (stop_s1.demand_one),
		.capacity (capacity_one_q),
		.penalty  (pen_one)
	);

	rpop_lane #(.ACC_BITS(ACC_BITS)) u_lane_two (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.demand   (stop_s1.demand_two),
		.capacity (capacity_two_q),
		.penalty  (pen_two)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid       <= 1'b0;
			out_valid_q    <= 1'b0;
			trip_open_q    <= 1'b0;
			pickup_seen_q  <= 1'b0;
			capacity_one_q <= '0;
			capacity_two_q <= '0;
		end else begin
			if (in_ready) begin
				s1_valid <= in_valid;
			end
			if (ctrl.clear_total) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (stop_s1.last_stop) begin
					trip_open_q <= 1'b0;
				end else if (stop_s1.is_depot) begin
					trip_open_q <= 1'b1;
				end
			end
			if (ctrl.close) begin
				pickup_seen_q <= 1'b0;
			end else if (ctrl.load && ctrl.is_pickup) begin
				pickup_seen_q <= 1'b1;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_CAPACITY_ONE: capacity_one_q <= cfg_data;
					CFG_CAPACITY_TWO: capacity_two_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			stop_s1 <= in_item;
		end
		if (ctrl.clear_total) begin
			result_q.penalty_one <= pen_one;
			result_q.penalty_two <= pen_two;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = result_q;

endmodule

`default_nettype wire

FILE: rtl/rpop_checker.sv
// Port-level checker for route_pickup_overload_penalty_unit, with the bind that attaches it.
// Depends on rpop_pkg and the top level's ports.
`default_nettype none

module rpop_checker
	import rpop_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_ready,
	input wire stop_t    in_item,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire penalty_t out_item
);

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Stalled result item was dropped.");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_item))
		else $error("Stalled result item changed.");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("Input stalled while the output could take a result.");

	a_last_waits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && in_valid && in_ready && in_item.last_stop
		|=> (out_ready || !in_ready))
		else $error("Second last stop was not held behind a stalled result.");

endmodule

bind route_pickup_overload_penalty_unit rpop_checker u_rpop_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for route_pickup_overload_penalty_unit.
// Streams routes of stops under several capacity settings and idling patterns and checks
// every penalty item against an internal predictor. Depends on rpop_pkg and the RTL only.
`default_nettype none

module testbench
	import rpop_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_OTHER = 2'd2;
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam longint LOAD_LIMIT = (longint'(1) <<< ACC_BITS_DEFAULT) - 1;
	localparam int unsigned STOPS_PER_PHASE = 75;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned WATCHDOG_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	stop_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	penalty_t out_item;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [DEMAND_BITS-1:0] cfg_data = '0;

	stop_t pending_stops[$];
	penalty_t expected_penalties[$];
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned stops_sent = 0;
	int unsigned penalties_checked = 0;
	int unsigned nonzero_penalties = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	// Predictor state; the arrays hold one entry per load dimension.
	logic [DEMAND_BITS-1:0] capacity[2] = '{default: '0};
	bit trip_open = 1'b0;
	bit pickup_seen = 1'b0;
	longint trip_delivery[2] = '{default: 0};
	longint net_change[2] = '{default: 0};
	longint best_net[2] = '{default: 0};
	longint route_total[2] = '{default: 0};

	route_pickup_overload_penalty_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic longint clamp_load(input longint v);
		if (v > LOAD_LIMIT) return LOAD_LIMIT;
		if (v < -LOAD_LIMIT) return -LOAD_LIMIT;
		return v;
	endfunction

	function automatic void close_trip();
		longint over;
		if (trip_open && pickup_seen) begin
			for (int i = 0; i < 2; i++) begin
				over = trip_delivery[i] + best_net[i] - longint'(capacity[i]);
				if (over > 0) begin
					route_total[i] = route_total[i] + over;
					if (route_total[i] > LOAD_LIMIT) route_total[i] = LOAD_LIMIT;
				end
			end
		end
		trip_delivery = '{default: 0};
		net_change = '{default: 0};
		best_net = '{default: 0};
		pickup_seen = 1'b0;
	endfunction

	function automatic void fold_stop(input stop_t s);
		longint demand[2];
		penalty_t penalty;
		demand[0] = longint'(s.demand_one);
		demand[1] = longint'(s.demand_two);
		if (s.last_stop) begin
			close_trip();
			penalty.penalty_one = route_total[0][PENALTY_BITS-1:0];
			penalty.penalty_two = route_total[1][PENALTY_BITS-1:0];
			expected_penalties.push_back(penalty);
			trip_open = 1'b0;
			route_total = '{default: 0};
			return;
		end
		if (s.is_depot) begin
			close_trip();
			trip_open = 1'b1;
			return;
		end
		if (!trip_open) return;
		for (int i = 0; i < 2; i++) begin
			if (s.req_type == REQ_DELIVERY) begin
				trip_delivery[i] = trip_delivery[i] + demand[i];
				if (trip_delivery[i] > LOAD_LIMIT) trip_delivery[i] = LOAD_LIMIT;
				net_change[i] = clamp_load(net_change[i] - demand[i]);
			end else begin
				net_change[i] = clamp_load(net_change[i] + demand[i]);
			end
			if (s.req_type == REQ_PICKUP && (!pickup_seen || net_change[i] > best_net[i]))
				best_net[i] = net_change[i];
		end
		if (s.req_type == REQ_PICKUP) pickup_seen = 1'b1;
	endfunction

	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (in_valid) begin
				fold_stop(in_item);
				stops_sent++;
			end
			if (pending_stops.size() != 0 && $urandom_range(99) >= idle_pct) begin
				in_valid <= 1'b1;
				in_item <= pending_stops.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		penalty_t want;
		if (out_valid && out_ready) begin
			if (expected_penalties.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected penalty item one=%0d two=%0d",
						out_item.penalty_one, out_item.penalty_two);
			end else begin
				want = expected_penalties.pop_front();
				penalties_checked++;
				if (want != '0) nonzero_penalties++;
				if (out_item.penalty_one !== want.penalty_one ||
					out_item.penalty_two !== want.penalty_two) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: expected one=%0d two=%0d, got one=%0d two=%0d",
							want.penalty_one, want.penalty_two,
							out_item.penalty_one, out_item.penalty_two);
				end
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
			(pending_stops.size() == 0 && !in_valid && expected_penalties.size() == 0)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic stop_t make_stop(input bit depot, input logic [1:0] kind,
		input logic [DEMAND_BITS-1:0] one, input logic [DEMAND_BITS-1:0] two, input bit last);
		stop_t s;
		s.is_depot = depot;
		s.req_type = kind;
		s.demand_one = one;
		s.demand_two = two;
		s.last_stop = last;
		return s;
	endfunction

	function automatic logic [DEMAND_BITS-1:0] draw_demand(input int unsigned span);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return DEMAND_BITS'($urandom);
			default: return DEMAND_BITS'($urandom_range(0, span));
		endcase
	endfunction

	function automatic logic [1:0] draw_kind();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return REQ_DELIVERY;
			4, 5, 6, 7: return REQ_PICKUP;
			8: return REQ_OTHER;
			default: return REQ_SPARE;
		endcase
	endfunction

	task automatic write_capacity(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [DEMAND_BITS-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		capacity[idx] = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_stops.size() != 0 || in_valid || expected_penalties.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A route is optional noise before the first depot, zero to three trips and a closing stop.
	task automatic queue_route(input int unsigned span, inout int unsigned queued);
		int unsigned trips;
		int unsigned body;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				pending_stops.push_back(make_stop(1'b0, draw_kind(), draw_demand(span),
					draw_demand(span), 1'b0));
				queued++;
			end
		end
		trips = $urandom_range(0, 3);
		repeat (trips) begin
			pending_stops.push_back(make_stop(1'b1, 2'($urandom), draw_demand(span),
				draw_demand(span), 1'b0));
			queued++;
			body = $urandom_range(0, 7);
			repeat (body) begin
				pending_stops.push_back(make_stop(1'b0, draw_kind(), draw_demand(span),
					draw_demand(span), 1'b0));
				queued++;
			end
		end
		pending_stops.push_back(make_stop(1'($urandom), 2'($urandom), draw_demand(span),
			draw_demand(span), 1'b1));
		queued++;
	endtask

	task automatic random_phase(input int unsigned idle, input int unsigned stall,
		input logic [DEMAND_BITS-1:0] cap_one, input logic [DEMAND_BITS-1:0] cap_two,
		input int unsigned span);
		int unsigned queued;
		write_capacity(CFG_CAPACITY_ONE, cap_one);
		write_capacity(CFG_CAPACITY_TWO, cap_two);
		idle_pct <= idle;
		stall_pct <= stall;
		queued = 0;
		while (queued < STOPS_PER_PHASE) queue_route(span, queued);
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_capacity(CFG_CAPACITY_ONE, 16'd100);
		write_capacity(CFG_CAPACITY_TWO, 16'd50);
		// Single-stop route, then a route with a stop ahead of its first depot, a trip
		// with every request type, a trip without pickups, one with a pickup and a closing stop marked depot.
		pending_stops.push_back(make_stop(1'b1, REQ_PICKUP, '1, '1, 1'b1));
		pending_stops.push_back(make_stop(1'b0, REQ_PICKUP, '1, '1, 1'b0));
		pending_stops.push_back(make_stop(1'b1, REQ_DELIVERY, '0, '0, 1'b0));
		pending_stops.push_back(make_stop(1'b0, REQ_DELIVERY, '1, '0, 1'b0));
		pending_stops.push_back(make_stop(1'b0, REQ_PICKUP, '1, '1, 1'b0));
		pending_stops.push_back(make_stop(1'b0, REQ_OTHER, '0, '1, 1'b0));
		pending_stops.push_back(make_stop(1'b0, REQ_SPARE, 16'd1, 16'd1, 1'b0));
		pending_stops.push_back(make_stop(1'b0, REQ_PICKUP, '0, '0, 1'b0));
		pending_stops.push_back(make_stop(1'b1, REQ_PICKUP, '1, '1, 1'b0));
		pending_stops.push_back(make_stop(1'b0, REQ_DELIVERY, 16'd20, 16'd30, 1'b0));
		pending_stops.push_back(make_stop(1'b0, REQ_OTHER, 16'd500, 16'd500, 1'b0));
		pending_stops.push_back(make_stop(1'b1, REQ_OTHER, '0, '0, 1'b0));
		pending_stops.push_back(make_stop(1'b0, REQ_PICKUP, 16'd150, 16'd10, 1'b0));
		pending_stops.push_back(make_stop(1'b1, REQ_PICKUP, '1, '1, 1'b1));
		// Deliveries ahead of pickups drive the net change below zero first.
		pending_stops.push_back(make_stop(1'b1, REQ_DELIVERY, '0, '0, 1'b0));
		pending_stops.push_back(make_stop(1'b0, REQ_DELIVERY, 16'd80, 16'd80, 1'b0));
		pending_stops.push_back(make_stop(1'b0, REQ_PICKUP, '0, '0, 1'b0));
		pending_stops.push_back(make_stop(1'b0, REQ_DELIVERY, 16'd10, 16'd10, 1'b0));
		pending_stops.push_back(make_stop(1'b0, REQ_PICKUP, 16'd40, 16'd40, 1'b0));
		pending_stops.push_back(make_stop(1'b0, REQ_PICKUP, 16'd5, 16'd60, 1'b0));
		pending_stops.push_back(make_stop(1'b0, REQ_SPARE, '1, '0, 1'b1));
		drain();

		random_phase(0, 0, 16'd0, 16'hFFFF, 300);
		random_phase(71, 0, 16'hFFFF, 16'd0, 300);
		random_phase(0, 71, DEMAND_BITS'($urandom_range(0, 600)),
			DEMAND_BITS'($urandom_range(0, 600)), 400);
		random_phase(11, 11, DEMAND_BITS'($urandom_range(0, 300)),
			DEMAND_BITS'($urandom_range(0, 300)), 200);
		random_phase(0, 0, DEMAND_BITS'($urandom), DEMAND_BITS'($urandom), 65535);

		$display("Run covered %0d stops and %0d route penalties (%0d nonzero) over six settings.",
			stops_sent, penalties_checked, nonzero_penalties);
		$display("Mismatches: %0d, penalties still outstanding: %0d.",
			mismatches, expected_penalties.size());
		if (mismatches == 0 && expected_penalties.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
